[hdl/amcp_pkg.sv]
// ----------------------------------------------------------------------------
// amcp_pkg: shared types and constants for the ASCII motor command parser
// Command codes, keyword tables, character codes and the result record.
// ----------------------------------------------------------------------------
package amcp_pkg;

	localparam int LINE_CAPACITY_DEF = 64;

	// line positions are compared at this width (covers capacity up to 512)
	localparam int POS_W = 9;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	typedef enum logic [3:0] {
		CMD_START_FWD = 4'd0,
		CMD_START_REV = 4'd1,
		CMD_BAD_DIR   = 4'd2,
		CMD_STOP      = 4'd3,
		CMD_REVERSE   = 4'd4,
		CMD_SPEED     = 4'd5,
		CMD_CALIBRATE = 4'd6,
		CMD_SENSORS   = 4'd7,
		CMD_STATUS    = 4'd8,
		CMD_UNKNOWN   = 4'd9
	} cmd_t;

	localparam int KW_COUNT     = 10;
	localparam int KW_START     = 0;
	localparam int KW_START_FWD = 1;
	localparam int KW_START_REV = 2;
	localparam int KW_START_ANY = 3;
	localparam int KW_STOP      = 4;
	localparam int KW_REV       = 5;
	localparam int KW_SPEED     = 6;
	localparam int KW_CALIBRATE = 7;
	localparam int KW_SENSORS   = 8;
	localparam int KW_STATUS    = 9;

	localparam int KW_MAX_LEN = 9;
	localparam int SPEED_AT   = 6;
	localparam int SENSORS_AT = 8;

	// keyword text, first character in the top byte, padded with spaces
	localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
		"START    ",
		"START:FWD",
		"START:REV",
		"START:   ",
		"STOP     ",
		"REV      ",
		"SPEED:   ",
		"CALIBRATE",
		"SENSORS: ",
		"STATUS   "
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd5, 4'd9, 4'd9, 4'd6, 4'd4, 4'd3, 4'd6, 4'd9, 4'd8, 4'd6
	};

	// keywords that only need to match the start of the line
	localparam logic [KW_COUNT-1:0] KW_PREFIX = 10'b01_0100_1000;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] speed_rpm;
		logic        home_closed;
		logic        rewind_closed;
	} res_t;

	function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
		int sh;
		sh = 8 * (KW_MAX_LEN - 1 - int'(i));
		return KW_TEXT[k][sh +: 8];
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A]}) ? c - 8'h20 : c;
	endfunction

endpackage

[hdl/amcp_line.sv]
// ----------------------------------------------------------------------------
// amcp_line: per-line matching state
// Tracks keyword candidates, the speed number and the sensor fields as bytes
// arrive; flags a finished line and presents its decoded result.
// ----------------------------------------------------------------------------
module amcp_line #(
	parameter int LINE_CAPACITY = amcp_pkg::LINE_CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	output logic             line_done,
	output amcp_pkg::res_t   result
);
	import amcp_pkg::*;

	localparam int CW = $clog2(LINE_CAPACITY);
	localparam logic [CW-1:0] LAST_POS = CW'(LINE_CAPACITY - 1);

	typedef enum logic [1:0] {
		NUM_LEAD, NUM_SIGN, NUM_DIGITS, NUM_DONE
	} num_phase_t;

	typedef enum logic [2:0] {
		SEN_H_LEAD, SEN_H_SIGN, SEN_H_DIGITS,
		SEN_R_LEAD, SEN_R_SIGN, SEN_R_DIGITS, SEN_DONE
	} sen_phase_t;

	logic [CW-1:0]       count_q, count_d;
	logic [KW_COUNT-1:0] alive_q, alive_d;
	logic                ended_q, ended_d;
	logic [31:0]         num_val_q, num_val_d;
	num_phase_t          num_phase_q, num_phase_d;
	logic                num_neg_q, num_neg_d;
	logic                num_sat_q, num_sat_d;
	sen_phase_t          sen_phase_q, sen_phase_d;
	logic                home_q, home_d;
	logic                rew_q, rew_d;

	logic [POS_W-1:0]    pos_w;
	logic [3:0]          pos_c;
	logic [7:0]          up;
	logic                eol, full, dig, sign;
	logic [35:0]         acc;
	logic [KW_COUNT-1:0] hit, len_ok_pos, len_ok_cnt, alive_fin;

	assign eol    = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
	assign full   = (count_q == LAST_POS);
	assign pos_w  = POS_W'(count_q);
	assign pos_c  = (pos_w < POS_W'(KW_MAX_LEN)) ? pos_w[3:0] : 4'd0;
	assign up     = to_upper(rx_byte);
	assign dig    = is_digit(rx_byte);
	assign sign   = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
	assign acc    = ({4'd0, num_val_q} << 3) + ({4'd0, num_val_q} << 1)
	              + 36'(rx_byte - CHAR_ZERO);

	// candidate checks for this byte and for the line length
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			if (pos_w < POS_W'(KW_LEN[k]))
				hit[k] = (up == kw_char(k, pos_c));
			else
				hit[k] = KW_PREFIX[k];
			len_ok_pos[k] = KW_PREFIX[k] ? (pos_w >= POS_W'(KW_LEN[k]))
			                             : (pos_w == POS_W'(KW_LEN[k]));
			len_ok_cnt[k] = len_ok_pos[k];
		end
	end

	assign line_done = eol && (count_q != '0);
	assign alive_fin = ended_q ? alive_q : (alive_q & len_ok_cnt);

	always_comb begin
		result = '0;
		result.cmd = CMD_UNKNOWN;
		if (alive_fin[KW_START])
			result.cmd = CMD_START_FWD;
		else if (alive_fin[KW_START_ANY])
			result.cmd = alive_fin[KW_START_FWD] ? CMD_START_FWD :
			             alive_fin[KW_START_REV] ? CMD_START_REV : CMD_BAD_DIR;
		else if (alive_fin[KW_STOP])
			result.cmd = CMD_STOP;
		else if (alive_fin[KW_REV])
			result.cmd = CMD_REVERSE;
		else if (alive_fin[KW_SPEED]) begin
			result.cmd = CMD_SPEED;
			if (num_sat_q)
				result.speed_rpm = '1;
			else
				result.speed_rpm = num_neg_q ? (32'd0 - num_val_q) : num_val_q;
		end else if (alive_fin[KW_CALIBRATE])
			result.cmd = CMD_CALIBRATE;
		else if (alive_fin[KW_SENSORS]) begin
			result.cmd = CMD_SENSORS;
			result.home_closed = home_q;
			result.rewind_closed = rew_q;
		end else if (alive_fin[KW_STATUS])
			result.cmd = CMD_STATUS;
	end

	always_comb begin
		count_d     = count_q;
		alive_d     = alive_q;
		ended_d     = ended_q;
		num_val_d   = num_val_q;
		num_phase_d = num_phase_q;
		num_neg_d   = num_neg_q;
		num_sat_d   = num_sat_q;
		sen_phase_d = sen_phase_q;
		home_d      = home_q;
		rew_d       = rew_q;
		if (eol) begin
			if (count_q != '0) begin
				count_d     = '0;
				alive_d     = '1;
				ended_d     = 1'b0;
				num_val_d   = '0;
				num_phase_d = NUM_LEAD;
				num_neg_d   = 1'b0;
				num_sat_d   = 1'b0;
				sen_phase_d = SEN_H_LEAD;
				home_d      = 1'b0;
				rew_d       = 1'b0;
			end
		end else if (!full) begin
			count_d = count_q + 1'b1;
			if (!ended_q) begin
				if (rx_byte == CHAR_NUL) begin
					ended_d = 1'b1;
					alive_d = alive_q & len_ok_pos;
				end else begin
					alive_d = alive_q & hit;

					if (pos_w >= POS_W'(SPEED_AT) && num_phase_q != NUM_DONE) begin
						if (dig) begin
							if (!num_sat_q) begin
								if (acc[35:32] != 4'd0) begin
									num_sat_d = 1'b1;
									num_val_d = '1;
								end else
									num_val_d = acc[31:0];
							end
							num_phase_d = NUM_DIGITS;
						end else if (num_phase_q == NUM_LEAD && is_space(rx_byte)) begin
							num_phase_d = NUM_LEAD;
						end else if (num_phase_q == NUM_LEAD && sign) begin
							num_neg_d   = (rx_byte == CHAR_MINUS);
							num_phase_d = NUM_SIGN;
						end else
							num_phase_d = NUM_DONE;
					end

					if (pos_w >= POS_W'(SENSORS_AT)) begin
						case (sen_phase_q)
							SEN_H_LEAD, SEN_H_SIGN, SEN_H_DIGITS: begin
								if (dig) begin
									if (rx_byte != CHAR_ZERO)
										home_d = 1'b1;
									sen_phase_d = SEN_H_DIGITS;
								end else if (sen_phase_q == SEN_H_LEAD && is_space(rx_byte))
									sen_phase_d = SEN_H_LEAD;
								else if (sen_phase_q == SEN_H_LEAD && sign)
									sen_phase_d = SEN_H_SIGN;
								else if (sen_phase_q == SEN_H_DIGITS && rx_byte == CHAR_COMMA)
									sen_phase_d = SEN_R_LEAD;
								else
									sen_phase_d = SEN_DONE;
							end
							SEN_R_LEAD, SEN_R_SIGN, SEN_R_DIGITS: begin
								if (dig) begin
									if (rx_byte != CHAR_ZERO)
										rew_d = 1'b1;
									sen_phase_d = SEN_R_DIGITS;
								end else if (sen_phase_q == SEN_R_LEAD && is_space(rx_byte))
									sen_phase_d = SEN_R_LEAD;
								else if (sen_phase_q == SEN_R_LEAD && sign)
									sen_phase_d = SEN_R_SIGN;
								else
									sen_phase_d = SEN_DONE;
							end
							default: sen_phase_d = SEN_DONE;
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			alive_q     <= '1;
			ended_q     <= 1'b0;
			num_val_q   <= '0;
			num_phase_q <= NUM_LEAD;
			num_neg_q   <= 1'b0;
			num_sat_q   <= 1'b0;
			sen_phase_q <= SEN_H_LEAD;
			home_q      <= 1'b0;
			rew_q       <= 1'b0;
		end else if (step) begin
			count_q     <= count_d;
			alive_q     <= alive_d;
			ended_q     <= ended_d;
			num_val_q   <= num_val_d;
			num_phase_q <= num_phase_d;
			num_neg_q   <= num_neg_d;
			num_sat_q   <= num_sat_d;
			sen_phase_q <= sen_phase_d;
			home_q      <= home_d;
			rew_q       <= rew_d;
		end
	end

endmodule

[hdl/ascii_motor_command_parser.sv]
// ----------------------------------------------------------------------------
// ascii_motor_command_parser: line-based ASCII motor command decoder
// Bytes in on s_axis, one decoded command word out on m_axis per line.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per word. CR or LF closes a non-empty
//   line; empty lines are swallowed. Each closed line yields one m_axis word:
//   tuser holds the command code, tdata the speed value and the two sensor
//   flags (zero unless the command uses them).
//   Path: a line-end byte is taken into the input register, then its result
//   is captured in the result register and shown on m_axis.
//   Throughput: one byte per cycle; all per-byte matching and the
//   multiply-by-ten accumulate sit between the input and result registers.
//   The input stage stalls only when a line-end byte is waiting while the
//   result register still holds an untaken word; other bytes keep flowing
//   while the receiver stalls.
//   Reset (arst_n low) clears the line state and the valid flags of the
//   input stage and the result register; the block is ready right after
//   reset, with no initialization sweep.
// ----------------------------------------------------------------------------
module ascii_motor_command_parser #(
	parameter int LINE_CAPACITY = amcp_pkg::LINE_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] speed_rpm, [32] home_closed,
	                                    // [33] rewind_closed, [39:34] zero
	output logic [3:0]  m_axis_tuser    // [3:0] command
);
	import amcp_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_s1;
	logic       line_done, out_free, advance;
	res_t       result, res_q;
	logic       m_valid_q;

	amcp_line #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.rx_byte  (rx_s1),
		.line_done(line_done),
		.result   (result)
	);

	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!line_done || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			rx_s1 <= s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_free)
			m_valid_q <= advance && line_done;
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && line_done)
			res_q <= result;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = res_q.cmd;
	assign m_axis_tdata  = {6'd0, res_q.rewind_closed, res_q.home_closed, res_q.speed_rpm};

endmodule

[hdl/amcp_checker.sv]
// ----------------------------------------------------------------------------
// amcp_checker: port-level checks for the command parser
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module amcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser
);
	import amcp_pkg::*;

	// nothing offered on the output while reset is applied
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("m_axis_tvalid high during reset");

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// a new word needs a byte taken earlier on the input
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a line-end byte two cycles earlier");

	// speed field only for speed, flags only for sensors, padding zero
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[39:34] == 6'd0) &&
			(m_axis_tuser == CMD_SPEED || m_axis_tdata[31:0] == 32'd0) &&
			(m_axis_tuser == CMD_SENSORS || m_axis_tdata[33:32] == 2'd0))
		else $error("unused result fields not zero");

endmodule

bind ascii_motor_command_parser amcp_checker u_amcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

[test/tb_ascii_motor_command_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_motor_command_parser: self-checking bench for the command parser
// Streams text lines into s_axis byte by byte and predicts the command word
// for every closed line. Each m_axis word is checked field by field in order.
// Covers directed keyword cases, random well-formed and broken lines, random
// idling on both sides and a long output hold that stalls the input.
// ----------------------------------------------------------------------------
module tb_ascii_motor_command_parser;
	import amcp_pkg::*;

	localparam int LINE_CAP       = LINE_CAPACITY_DEF;
	localparam int IDLE_PCT       = 17;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int RANDOM_BYTES   = 320;

	// keyword slots, in priority order
	localparam int KW_N        = 10;
	localparam int W_START     = 0;
	localparam int W_START_FWD = 1;
	localparam int W_START_REV = 2;
	localparam int W_START_ANY = 3;
	localparam int W_STOP      = 4;
	localparam int W_REV       = 5;
	localparam int W_SPEED     = 6;
	localparam int W_CALIB     = 7;
	localparam int W_SENSORS   = 8;
	localparam int W_STATUS    = 9;
	localparam logic [KW_N-1:0] PREFIX_KW =
		(10'd1 << W_START_ANY) | (10'd1 << W_SPEED) | (10'd1 << W_SENSORS);

	// numeric field reader phases
	localparam int FLD_LEAD   = 0;
	localparam int FLD_SIGN   = 1;
	localparam int FLD_DIGITS = 2;
	localparam int FLD_DONE   = 3;
	localparam int SENS_DONE  = 2;   // sensor field index once both are read
	localparam int RPM_FROM   = 6;
	localparam int SENS_FROM  = 8;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] rpm;
		logic        home;
		logic        rewind;
	} line_result_t;

	string keyword_txt [KW_N] = '{"START", "START:FWD", "START:REV", "START:", "STOP",
		"REV", "SPEED:", "CALIBRATE", "SENSORS:", "STATUS"};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	// predictor state
	int unsigned line_len;
	logic [KW_N-1:0] cand_alive;
	bit          text_cut;
	logic [31:0] rpm_acc;
	int          rpm_phase;
	bit          rpm_neg;
	bit          rpm_sat;
	int          sens_field;
	int          sens_phase;
	bit          home_seen;
	bit          rewind_seen;

	line_result_t expected_cmds [$];

	bit calm;
	int hold_req;
	int hold_left;
	int mismatches;
	int words_checked;
	int bytes_sent;
	int lines_closed;

	ascii_motor_command_parser #(
		.LINE_CAPACITY(LINE_CAP)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// line predictor
	// ------------------------------------------------------------------------
	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit is_dec(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic void clear_line();
		line_len    = 0;
		cand_alive  = '1;
		text_cut    = 1'b0;
		rpm_acc     = '0;
		rpm_phase   = FLD_LEAD;
		rpm_neg     = 1'b0;
		rpm_sat     = 1'b0;
		sens_field  = 0;
		sens_phase  = FLD_LEAD;
		home_seen   = 1'b0;
		rewind_seen = 1'b0;
	endfunction

	// drop candidates whose length no longer fits the text
	function automatic void trim_candidates(input int unsigned n);
		int klen;
		bit ok;
		for (int k = 0; k < KW_N; k++) begin
			klen = keyword_txt[k].len();
			ok = PREFIX_KW[k] ? (n >= klen) : (n == klen);
			if (!ok)
				cand_alive[k] = 1'b0;
		end
	endfunction

	function automatic void match_char(input int unsigned p, input logic [7:0] c);
		logic [7:0] kc;
		bit keep;
		for (int k = 0; k < KW_N; k++) begin
			if (p < keyword_txt[k].len()) begin
				kc = keyword_txt[k][p];
				keep = upcase(c) == kc;
			end else begin
				keep = PREFIX_KW[k];
			end
			if (!keep)
				cand_alive[k] = 1'b0;
		end
	endfunction

	function automatic void rpm_char(input logic [7:0] c);
		longint unsigned v;
		if (rpm_phase == FLD_DONE)
			return;
		if (is_dec(c)) begin
			if (!rpm_sat) begin
				v = rpm_acc;
				v = v * 10 + c - 8'h30;
				if (v > 64'hFFFF_FFFF) begin
					rpm_sat = 1'b1;
					rpm_acc = '1;
				end else begin
					rpm_acc = v[31:0];
				end
			end
			rpm_phase = FLD_DIGITS;
		end else if (rpm_phase == FLD_LEAD && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
			rpm_neg = c == CHAR_MINUS;
			rpm_phase = FLD_SIGN;
		end else if (!(rpm_phase == FLD_LEAD && is_blank(c))) begin
			rpm_phase = FLD_DONE;
		end
	endfunction

	function automatic void sensor_char(input logic [7:0] c);
		if (sens_field == SENS_DONE)
			return;
		if (is_dec(c)) begin
			if (c != CHAR_ZERO) begin
				if (sens_field == 0)
					home_seen = 1'b1;
				else
					rewind_seen = 1'b1;
			end
			sens_phase = FLD_DIGITS;
		end else if (sens_phase == FLD_LEAD && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
			sens_phase = FLD_SIGN;
		end else if (sens_phase == FLD_DIGITS && sens_field == 0 && c == CHAR_COMMA) begin
			sens_field = 1;
			sens_phase = FLD_LEAD;
		end else if (!(sens_phase == FLD_LEAD && is_blank(c))) begin
			sens_field = SENS_DONE;
		end
	endfunction

	function automatic void predict_byte(input logic [7:0] c);
		int unsigned pos;
		line_result_t r;
		if (c != CHAR_CR && c != CHAR_LF) begin
			if (line_len < LINE_CAP - 1) begin
				pos = line_len;
				line_len++;
				if (!text_cut) begin
					if (c == CHAR_NUL) begin
						text_cut = 1'b1;
						trim_candidates(pos);
					end else begin
						match_char(pos, c);
						if (pos >= RPM_FROM)
							rpm_char(c);
						if (pos >= SENS_FROM)
							sensor_char(c);
					end
				end
			end
		end else if (line_len != 0) begin
			if (!text_cut)
				trim_candidates(line_len);
			r.cmd    = CMD_UNKNOWN;
			r.rpm    = '0;
			r.home   = 1'b0;
			r.rewind = 1'b0;
			if (cand_alive[W_START]) begin
				r.cmd = CMD_START_FWD;
			end else if (cand_alive[W_START_ANY]) begin
				if (cand_alive[W_START_FWD])
					r.cmd = CMD_START_FWD;
				else if (cand_alive[W_START_REV])
					r.cmd = CMD_START_REV;
				else
					r.cmd = CMD_BAD_DIR;
			end else if (cand_alive[W_STOP]) begin
				r.cmd = CMD_STOP;
			end else if (cand_alive[W_REV]) begin
				r.cmd = CMD_REVERSE;
			end else if (cand_alive[W_SPEED]) begin
				r.cmd = CMD_SPEED;
				r.rpm = rpm_sat ? '1 : (rpm_neg ? 32'd0 - rpm_acc : rpm_acc);
			end else if (cand_alive[W_CALIB]) begin
				r.cmd = CMD_CALIBRATE;
			end else if (cand_alive[W_SENSORS]) begin
				r.cmd    = CMD_SENSORS;
				r.home   = home_seen;
				r.rewind = rewind_seen;
			end else if (cand_alive[W_STATUS]) begin
				r.cmd = CMD_STATUS;
			end
			expected_cmds.push_back(r);
			lines_closed++;
			clear_line();
		end
	endfunction

	// ------------------------------------------------------------------------
	// receiver: random stalls plus an on-demand long hold
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// command word checker
	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_cmds.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected word, expected none, got tuser %0d tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
			end else begin
				want = expected_cmds.pop_front();
				words_checked++;
				if (m_axis_tuser !== want.cmd) begin
					mismatches++;
					$display("%0t ns: command expected %s (%0d) got %0d", $time,
						want.cmd.name(), want.cmd, m_axis_tuser);
				end
				if (m_axis_tdata[31:0] !== want.rpm) begin
					mismatches++;
					$display("%0t ns: speed_rpm expected %0d got %0d", $time,
						want.rpm, m_axis_tdata[31:0]);
				end
				if (m_axis_tdata[32] !== want.home) begin
					mismatches++;
					$display("%0t ns: home_closed expected %b got %b", $time,
						want.home, m_axis_tdata[32]);
				end
				if (m_axis_tdata[33] !== want.rewind) begin
					mismatches++;
					$display("%0t ns: rewind_closed expected %b got %b", $time,
						want.rewind, m_axis_tdata[33]);
				end
				if (m_axis_tdata[39:34] !== '0) begin
					mismatches++;
					$display("%0t ns: tdata pad expected 0 got %b", $time,
						m_axis_tdata[39:34]);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'($urandom);
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line(input string s);
		send_text(s);
		send_byte(CHAR_CR);
	endtask

	function automatic void add_text(ref logic [7:0] q [$], input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return 8'h09;
			1: return 8'h0B;
			2: return 8'h0C;
			default: return CHAR_SPACE;
		endcase
	endfunction

	// whitespace, sign and digits; sometimes the overflow boundary or a stray byte after
	function automatic void add_number(ref logic [7:0] q [$]);
		int n;
		n = $urandom_range(0, 2);
		repeat (n) q.push_back(pick_blank());
		case ($urandom_range(0, 3))
			1: q.push_back(CHAR_PLUS);
			2: q.push_back(CHAR_MINUS);
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: n = 0;
			1: begin add_text(q, "4294967295"); n = 0; end
			2: begin add_text(q, "4294967296"); n = 0; end
			3: n = $urandom_range(11, 14);
			default: n = $urandom_range(1, 6);
		endcase
		repeat (n) q.push_back(8'($urandom_range(8'h30, 8'h39)));
		if ($urandom_range(0, 4) == 0)
			q.push_back(8'($urandom_range(8'h21, 8'h7E)));
	endfunction

	function automatic void add_flag_field(ref logic [7:0] q [$]);
		int n;
		if ($urandom_range(0, 3) == 0)
			q.push_back(pick_blank());
		if ($urandom_range(0, 3) == 0)
			q.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
		n = $urandom_range(0, 3);
		repeat (n)
			q.push_back($urandom_range(0, 2) == 0 ? 8'($urandom_range(8'h31, 8'h39)) : CHAR_ZERO);
	endfunction

	task automatic send_random_line();
		logic [7:0] q [$];
		int kind;
		int n;
		string s;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			add_text(q, "START");
			case ($urandom_range(0, 4))
				1: add_text(q, ":FWD");
				2: add_text(q, ":REV");
				3: add_text(q, ":");
				4: begin
					add_text(q, ":");
					repeat ($urandom_range(1, 4))
						q.push_back(8'($urandom_range(8'h21, 8'h7E)));
				end
				default: ;
			endcase
		end else if (kind < 16) begin
			add_text(q, "STOP");
		end else if (kind < 24) begin
			add_text(q, "REV");
		end else if (kind < 44) begin
			add_text(q, "SPEED:");
			add_number(q);
		end else if (kind < 50) begin
			add_text(q, "CALIBRATE");
		end else if (kind < 66) begin
			add_text(q, "SENSORS:");
			add_flag_field(q);
			if ($urandom_range(0, 6) == 0)
				q.push_back(CHAR_SPACE);
			if ($urandom_range(0, 9) < 7) begin
				q.push_back(CHAR_COMMA);
				add_flag_field(q);
			end
		end else if (kind < 74) begin
			add_text(q, "STATUS");
		end else if (kind < 82) begin
			// near miss: keyword cut short or with a byte too many
			s = keyword_txt[$urandom_range(0, KW_N - 1)];
			if ($urandom_range(0, 1))
				add_text(q, s.substr(0, s.len() - 2));
			else begin
				add_text(q, s);
				q.push_back(8'($urandom_range(8'h21, 8'h7E)));
			end
		end else if (kind < 90) begin
			n = $urandom_range(1, 12);
			repeat (n) q.push_back(8'($urandom));
		end else if (kind < 95) begin
			add_text(q, keyword_txt[$urandom_range(0, KW_N - 1)]);
			if ($urandom_range(0, 1))
				add_number(q);
			q.insert($urandom_range(0, q.size()), CHAR_NUL);
		end else if (kind < 97) begin
			n = $urandom_range(1, 3);
			repeat (n) q.push_back(pick_blank());
		end else begin
			add_text(q, keyword_txt[$urandom_range(0, KW_N - 1)]);
			n = $urandom_range(50, 75);
			repeat (n) q.push_back(8'($urandom_range(8'h21, 8'h7E)));
		end
		foreach (q[i])
			if (q[i] >= 8'h41 && q[i] <= 8'h5A && $urandom_range(0, 1))
				q[i] = q[i] + 8'h20;
		foreach (q[i])
			send_byte(q[i]);
		case ($urandom_range(0, 2))
			0: send_byte(CHAR_CR);
			1: send_byte(CHAR_LF);
			default: begin
				send_byte(CHAR_CR);
				send_byte(CHAR_LF);
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_directed_lines();
		send_byte(CHAR_CR);                 // empty line right after reset
		send_line("START");
		send_text("start:fwd");
		send_byte(CHAR_LF);
		send_text("Start:Rev");
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);                 // LF after CR closes nothing
		send_line("START:up");
		send_line("START:");
		send_line("StOp");
		send_line("rev");
		send_line("SPEED:1500");
		send_text("speed:");
		send_byte(8'h09);
		send_byte(8'h0B);
		send_byte(8'h0C);
		send_line(" -1");
		send_line("SPEED:+4294967295");
		send_line("SPEED:4294967296");
		send_line("SPEED:-99999999999");
		send_line("SPEED:");
		send_line("SPEED:12x34");
		send_line("calibrate");
		send_line("SENSORS:1,0");
		send_line("sensors: -0,+7");
		send_line("SENSORS:05 ,9");
		send_line("status");
		send_line("STATUSES");
		// zero byte: ends the matchable text
		send_byte(CHAR_NUL);
		send_byte(CHAR_CR);
		send_text("STOP");
		send_byte(CHAR_NUL);
		send_line("xyz");
		send_text("SPE");
		send_byte(CHAR_NUL);
		send_line("ED:5");
		send_text("SPEED:12");
		send_byte(CHAR_NUL);
		send_line("34");
		// full lines: extra bytes are dropped
		send_text("STATUS");
		repeat (70) send_byte(8'h41);
		send_byte(CHAR_CR);
		send_text("SPEED:");
		repeat (70) send_byte(8'h31);
		send_byte(CHAR_LF);
		// bytes above 0x7F never match a letter
		send_text("ST");
		send_byte(8'hD3);
		send_text("P");
		send_byte(8'hFF);
		send_byte(CHAR_LF);
	endtask

	task automatic test_steady_stream();
		int first;
		first = bytes_sent;
		calm = 1'b1;
		while (bytes_sent - first < 150)
			send_random_line();
		calm = 1'b0;
	endtask

	// receiver stops for a long stretch while full-rate lines keep coming
	task automatic test_output_hold();
		calm = 1'b1;
		hold_req = HOLD_CYCLES;
		repeat (10) begin
			send_line("STOP");
			send_line("SPEED:7");
		end
		calm = 1'b0;
	endtask

	task automatic test_random_lines();
		int first;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES)
			send_random_line();
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns: no word moved for %0d cycles", $time, quiet);
		$display("FAIL ascii_motor_command_parser");
		$finish;
	end

	initial begin : main
		int waited;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		calm = 1'b0;
		hold_req = 0;
		hold_left = 0;
		mismatches = 0;
		words_checked = 0;
		bytes_sent = 0;
		lines_closed = 0;
		clear_line();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_lines();
		test_steady_stream();
		test_output_hold();
		test_random_lines();

		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (expected_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_cmds.size() != 0) begin
			$display("%0t ns: %0d command words never arrived", $time, expected_cmds.size());
			$display("FAIL ascii_motor_command_parser");
		end else begin
			repeat (8) @(posedge clk);
			$display("Sent %0d bytes closing %0d lines; %0d command words checked.",
				bytes_sent, lines_closed, words_checked);
			$display("Included keyword edge cases, full lines, zero bytes and a %0d-cycle hold.",
				HOLD_CYCLES);
			if (mismatches == 0)
				$display("PASS ascii_motor_command_parser");
			else
				$display("FAIL ascii_motor_command_parser");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/amcp_pkg.sv
hdl/amcp_line.sv
hdl/ascii_motor_command_parser.sv
hdl/amcp_checker.sv
test/tb_ascii_motor_command_parser.sv
